@@ sv/acrf_pkg.sv @@
// ----------------------------------------------------------------------------
// acrf_pkg: shared types and constants of the AC remote IR frame encoder
// Frame layout constants, mode/fan codes, register indexes and pulse kinds.
// ----------------------------------------------------------------------------
package acrf_pkg;

  localparam int unsigned FrameLen  = 14;
  localparam int unsigned FrameBits = FrameLen * 8;
  localparam int unsigned IdxW      = 8;
  localparam logic [IdxW-1:0] FooterIdx = IdxW'(2 + 16 * FrameLen);

  // fixed header bytes
  localparam logic [7:0] HdrB0 = 8'h23;
  localparam logic [7:0] HdrB1 = 8'hCB;
  localparam logic [7:0] HdrB2 = 8'h26;
  localparam logic [7:0] HdrB3 = 8'h01;
  localparam logic [7:0] HdrSum = 8'(HdrB0 + HdrB1 + HdrB2 + HdrB3);

  localparam logic [7:0] PowerOn    = 8'h24;  // power bit 0x04 | 0x20
  localparam logic [7:0] TempBase   = 8'h1F;
  localparam logic [7:0] SwingBits  = 8'h38;

  // climate modes
  localparam logic [2:0] ModeOff  = 3'd0;
  localparam logic [2:0] ModeAuto = 3'd1;
  localparam logic [2:0] ModeHeat = 3'd2;
  localparam logic [2:0] ModeCool = 3'd3;
  localparam logic [2:0] ModeDry  = 3'd4;
  localparam logic [2:0] ModeFan  = 3'd5;

  // fan speeds
  localparam logic [2:0] FanLow  = 3'd1;
  localparam logic [2:0] FanMed  = 3'd2;
  localparam logic [2:0] FanHigh = 3'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgTempMin     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTempMax     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHeaderMark  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHeaderSpace = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBitMark     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOneSpace    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgZeroSpace   = 3'd6;

  // register reset values
  localparam logic [5:0]  RstTempMin     = 6'd16;
  localparam logic [5:0]  RstTempMax     = 6'd32;
  localparam logic [15:0] RstHeaderMark  = 16'd3000;
  localparam logic [15:0] RstHeaderSpace = 16'd1500;
  localparam logic [15:0] RstBitMark     = 16'd500;
  localparam logic [15:0] RstOneSpace    = 16'd1000;
  localparam logic [15:0] RstZeroSpace   = 16'd350;

  typedef enum logic [2:0] {
    PulseHdrMark,
    PulseHdrSpace,
    PulseBitMark,
    PulseOneSpace,
    PulseZeroSpace,
    PulseFooter
  } pulse_kind_e;

  typedef struct packed {
    logic        active;
    pulse_kind_e kind;
  } pulse_t;

  function automatic logic [7:0] mode_code(input logic [2:0] mode);
    logic [7:0] code;
    case (mode)
      ModeOff:  code = 8'h08;  // off sends auto
      ModeAuto: code = 8'h08;
      ModeHeat: code = 8'h01;
      ModeCool: code = 8'h03;
      ModeDry:  code = 8'h02;
      ModeFan:  code = 8'h07;
      default:  code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] fan_code(input logic [2:0] fan);
    logic [7:0] code;
    case (fan)
      FanLow:  code = 8'h02;
      FanMed:  code = 8'h03;
      FanHigh: code = 8'h05;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

@@ sv/acrf_in_if.sv @@
// ----------------------------------------------------------------------------
// acrf_in_if: request channel of the frame encoder
// Valid/ready channel carrying one load or next-pulse request.
// ----------------------------------------------------------------------------
interface acrf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] climate_mode;
  logic [2:0] fan_speed;
  logic       swing_on;
  logic [6:0] temp_half_deg;

  modport source (
    output valid, command, climate_mode, fan_speed, swing_on, temp_half_deg,
    input  ready
  );
  modport sink (
    input  valid, command, climate_mode, fan_speed, swing_on, temp_half_deg,
    output ready
  );
endinterface

@@ sv/acrf_out_if.sv @@
// ----------------------------------------------------------------------------
// acrf_out_if: pulse channel of the frame encoder
// Valid/ready channel carrying one IR pulse per next-pulse request.
// ----------------------------------------------------------------------------
interface acrf_out_if;
  logic        valid;
  logic        ready;
  logic        is_mark;
  logic [15:0] duration_us;
  logic        last_pulse;

  modport source (
    output valid, is_mark, duration_us, last_pulse,
    input  ready
  );
  modport sink (
    input  valid, is_mark, duration_us, last_pulse,
    output ready
  );
endinterface

@@ sv/acrf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// acrf_cfg_if: configuration write channel of the frame encoder
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface acrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ sv/acrf_frame_build.sv @@
// ----------------------------------------------------------------------------
// acrf_frame_build: frame assembly
// Rounds and clamps the temperature and packs the 14-byte frame, byte 0 in
// the low bits, with its mod-256 checksum.
// ----------------------------------------------------------------------------
module acrf_frame_build (
  input  logic [2:0]                        climate_mode_i,
  input  logic [2:0]                        fan_speed_i,
  input  logic                              swing_on_i,
  input  logic [6:0]                        temp_half_deg_i,
  input  logic [5:0]                        temp_min_i,
  input  logic [5:0]                        temp_max_i,
  output logic [acrf_pkg::FrameBits-1:0]    frame_o
);

  logic [6:0] t_round;
  logic [6:0] t_clamp;
  logic [7:0] b5, b6, b7, b8, b13;

  // round half up: (half + 1) >> 1, at most 64
  assign t_round = 7'((8'(temp_half_deg_i) + 8'd1) >> 1);

  always_comb begin
    if (t_round < {1'b0, temp_min_i}) begin
      t_clamp = {1'b0, temp_min_i};
    end else if (t_round > {1'b0, temp_max_i}) begin
      t_clamp = {1'b0, temp_max_i};
    end else begin
      t_clamp = t_round;
    end
  end

  assign b5  = (climate_mode_i == acrf_pkg::ModeOff) ? 8'h00 : acrf_pkg::PowerOn;
  assign b6  = acrf_pkg::mode_code(climate_mode_i);
  assign b7  = acrf_pkg::TempBase - {1'b0, t_clamp};
  assign b8  = (swing_on_i ? acrf_pkg::SwingBits : 8'h00) | acrf_pkg::fan_code(fan_speed_i);
  assign b13 = acrf_pkg::HdrSum + b5 + b6 + b7 + b8;

  always_comb begin
    frame_o         = '0;
    frame_o[7:0]    = acrf_pkg::HdrB0;
    frame_o[15:8]   = acrf_pkg::HdrB1;
    frame_o[23:16]  = acrf_pkg::HdrB2;
    frame_o[31:24]  = acrf_pkg::HdrB3;
    frame_o[47:40]  = b5;
    frame_o[55:48]  = b6;
    frame_o[63:56]  = b7;
    frame_o[71:64]  = b8;
    frame_o[acrf_pkg::FrameBits-1 -: 8] = b13;
  end

endmodule

@@ sv/acrf_pulse_seq.sv @@
// ----------------------------------------------------------------------------
// acrf_pulse_seq: pulse sequencer
// Holds the frame in a shift register and walks the pulse index; each bit
// space takes the low frame bit and shifts the register by one.
// ----------------------------------------------------------------------------
module acrf_pulse_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [acrf_pkg::FrameBits-1:0] frame_i,
  input  logic                           step_i,
  output acrf_pkg::pulse_t               pulse_o
);

  logic [acrf_pkg::FrameBits-1:0] frame_q, frame_d;
  logic [acrf_pkg::IdxW-1:0]      idx_q, idx_d;
  logic                           sending_q, sending_d;
  acrf_pkg::pulse_kind_e          kind;

  always_comb begin
    if (idx_q == '0) begin
      kind = acrf_pkg::PulseHdrMark;
    end else if (idx_q == acrf_pkg::IdxW'(1)) begin
      kind = acrf_pkg::PulseHdrSpace;
    end else if (idx_q == acrf_pkg::FooterIdx) begin
      kind = acrf_pkg::PulseFooter;
    end else if (!idx_q[0]) begin
      kind = acrf_pkg::PulseBitMark;
    end else begin
      kind = frame_q[0] ? acrf_pkg::PulseOneSpace : acrf_pkg::PulseZeroSpace;
    end
  end

  assign pulse_o.active = sending_q;
  assign pulse_o.kind   = kind;

  always_comb begin
    frame_d   = frame_q;
    idx_d     = idx_q;
    sending_d = sending_q;
    if (load_i) begin
      frame_d   = frame_i;
      idx_d     = '0;
      sending_d = 1'b1;
    end else if (step_i && sending_q) begin
      if (kind == acrf_pkg::PulseFooter) begin
        idx_d     = '0;
        sending_d = 1'b0;
      end else begin
        idx_d = idx_q + acrf_pkg::IdxW'(1);
      end
      if (kind == acrf_pkg::PulseOneSpace || kind == acrf_pkg::PulseZeroSpace) begin
        frame_d = frame_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      sending_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      sending_q <= sending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

@@ sv/ac_remote_ir_frame_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// ac_remote_ir_frame_encoder_unit: AC remote IR frame encoder
// Builds a 14-byte pulse-distance frame and emits it one pulse per next-pulse request.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   request channel. command 0 loads mode, fan, swing and temperature,
//          builds the frame and restarts at the header; it returns nothing.
//          command 1 asks for the next pulse; while idle it does nothing.
//   out_o  one pulse per next-pulse request: mark/space, duration, and
//          last_pulse on the footer mark, after which the block is idle.
//   cfg_i  register writes (temp_min, temp_max, five durations); always
//          ready, out-of-range indexes are dropped. Write only while idle.
// Timing: the pulse of a next-pulse request shows on out_o in the cycle
//   after acceptance. One request per cycle is sustained while out_o is
//   taken every cycle; the single output register sets that figure.
//   A full frame is 227 pulses (header 2, bits 224, footer 1).
// Reset: configuration registers return to their defaults, the sequencer goes idle and
//   out_o holds no pulse. The frame store is undefined until a load.
// Stall: while a pulse waits in the output register, in_i is not ready.
// ----------------------------------------------------------------------------
module ac_remote_ir_frame_encoder_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  acrf_in_if.sink       in_i,
  acrf_out_if.source    out_o,
  acrf_cfg_if.sink      cfg_i
);

  // configuration registers
  logic [5:0]  temp_min_q, temp_max_q;
  logic [15:0] hdr_mark_q, hdr_space_q, bit_mark_q, one_space_q, zero_space_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        is_mark_q, is_mark_d;
  logic [15:0] dur_q, dur_d;
  logic        last_q, last_d;

  logic                           in_take;
  logic                           load;
  logic                           step;
  logic [acrf_pkg::FrameBits-1:0] frame;
  acrf_pkg::pulse_t               pulse;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_take     = in_i.valid && in_i.ready;
  assign load        = in_take && !in_i.command;
  // a next-pulse request only produces output while a frame is in flight
  assign step        = in_take && in_i.command && pulse.active;

  assign cfg_i.ready = 1'b1;

  acrf_frame_build u_build (
    .climate_mode_i  (in_i.climate_mode),
    .fan_speed_i     (in_i.fan_speed),
    .swing_on_i      (in_i.swing_on),
    .temp_half_deg_i (in_i.temp_half_deg),
    .temp_min_i      (temp_min_q),
    .temp_max_i      (temp_max_q),
    .frame_o         (frame)
  );

  acrf_pulse_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .frame_i (frame),
    .step_i  (step),
    .pulse_o (pulse)
  );

  // pulse kind to mark flag and duration
  always_comb begin
    is_mark_d = is_mark_q;
    dur_d     = dur_q;
    last_d    = last_q;
    if (step) begin
      last_d = 1'b0;
      case (pulse.kind)
        acrf_pkg::PulseHdrMark: begin
          is_mark_d = 1'b1;
          dur_d     = hdr_mark_q;
        end
        acrf_pkg::PulseHdrSpace: begin
          is_mark_d = 1'b0;
          dur_d     = hdr_space_q;
        end
        acrf_pkg::PulseBitMark: begin
          is_mark_d = 1'b1;
          dur_d     = bit_mark_q;
        end
        acrf_pkg::PulseOneSpace: begin
          is_mark_d = 1'b0;
          dur_d     = one_space_q;
        end
        acrf_pkg::PulseZeroSpace: begin
          is_mark_d = 1'b0;
          dur_d     = zero_space_q;
        end
        acrf_pkg::PulseFooter: begin
          is_mark_d = 1'b1;
          dur_d     = bit_mark_q;
          last_d    = 1'b1;
        end
        default: begin
          is_mark_d = 1'b0;
          dur_d     = '0;
        end
      endcase
    end
  end

  always_comb begin
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_mark_q <= is_mark_d;
    dur_q     <= dur_d;
    last_q    <= last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.is_mark     = is_mark_q;
  assign out_o.duration_us = dur_q;
  assign out_o.last_pulse  = last_q;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_min_q   <= acrf_pkg::RstTempMin;
      temp_max_q   <= acrf_pkg::RstTempMax;
      hdr_mark_q   <= acrf_pkg::RstHeaderMark;
      hdr_space_q  <= acrf_pkg::RstHeaderSpace;
      bit_mark_q   <= acrf_pkg::RstBitMark;
      one_space_q  <= acrf_pkg::RstOneSpace;
      zero_space_q <= acrf_pkg::RstZeroSpace;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        acrf_pkg::CfgTempMin:     temp_min_q   <= cfg_i.data[5:0];
        acrf_pkg::CfgTempMax:     temp_max_q   <= cfg_i.data[5:0];
        acrf_pkg::CfgHeaderMark:  hdr_mark_q   <= cfg_i.data;
        acrf_pkg::CfgHeaderSpace: hdr_space_q  <= cfg_i.data;
        acrf_pkg::CfgBitMark:     bit_mark_q   <= cfg_i.data;
        acrf_pkg::CfgOneSpace:    one_space_q  <= cfg_i.data;
        acrf_pkg::CfgZeroSpace:   zero_space_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

endmodule
